@@ hdl/brm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brm_pkg
// types, codes and defaults shared by the execute core and its channels
// ---------------------------------------------------------------------------
package brm_pkg;

  // default sizes
  localparam int unsigned     REG_COUNT_DEF     = 8;
  localparam longint unsigned PROGRAM_DEPTH_DEF = 64'd65536;

  // item commands
  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_RET  = 1'b1;

  // opcodes
  localparam logic [4:0] OP_NOP     = 5'd0;
  localparam logic [4:0] OP_END     = 5'd1;
  localparam logic [4:0] OP_MARK    = 5'd2;
  localparam logic [4:0] OP_SET     = 5'd3;
  localparam logic [4:0] OP_SETR    = 5'd4;
  localparam logic [4:0] OP_SETD    = 5'd5;
  localparam logic [4:0] OP_SETC    = 5'd6;
  localparam logic [4:0] OP_SETM    = 5'd7;
  localparam logic [4:0] OP_ADD     = 5'd8;
  localparam logic [4:0] OP_ADDR    = 5'd9;
  localparam logic [4:0] OP_SUB     = 5'd10;
  localparam logic [4:0] OP_SUBR    = 5'd11;
  localparam logic [4:0] OP_SYSCALL = 5'd12;
  localparam logic [4:0] OP_GOTO    = 5'd13;
  localparam logic [4:0] OP_CGOTO   = 5'd14;
  localparam logic [4:0] OP_EQ      = 5'd15;
  localparam logic [4:0] OP_EQR     = 5'd16;
  localparam logic [4:0] OP_NEQ     = 5'd17;
  localparam logic [4:0] OP_NEQR    = 5'd18;
  localparam logic [4:0] OP_LT      = 5'd19;
  localparam logic [4:0] OP_LTR     = 5'd20;
  localparam logic [4:0] OP_GT      = 5'd21;
  localparam logic [4:0] OP_GTR     = 5'd22;
  localparam logic [4:0] OP_LE      = 5'd23;
  localparam logic [4:0] OP_LER     = 5'd24;
  localparam logic [4:0] OP_GE      = 5'd25;
  localparam logic [4:0] OP_GER     = 5'd26;

  // syscall ids
  localparam logic [7:0] SYS_EXIT  = 8'd1;
  localparam logic [7:0] SYS_WRITE = 8'd2;

  // exit kinds
  localparam logic [1:0] EXIT_RUN     = 2'd0;
  localparam logic [1:0] EXIT_END     = 2'd1;
  localparam logic [1:0] EXIT_SYS     = 2'd2;
  localparam logic [1:0] EXIT_UNKNOWN = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_OP  = 2'd1;
  localparam logic [1:0] ST_BAD_REG = 2'd2;
  localparam logic [1:0] ST_HALTED  = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic        [4:0]  opcode;
    logic        [7:0]  dst_index;
    logic        [7:0]  src_index;
    logic        [7:0]  src2_index;
    logic signed [63:0] immediate;
    logic        [15:0] target_index;
    logic        [7:0]  syscall_number;
    logic signed [63:0] table_value;
    logic signed [63:0] return_value;
  } brm_req_t;

  typedef struct packed {
    logic        [15:0] next_index;
    logic        [1:0]  exit_kind;
    logic signed [63:0] exit_value;
    logic        [1:0]  status;
    logic               write_request;
    logic signed [63:0] write_fd;
    logic signed [63:0] write_addr;
    logic signed [63:0] write_len;
  } brm_rsp_t;

endpackage

@@ hdl/brm_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brm_req_if
// instruction request channel with valid / ready handshake
// ---------------------------------------------------------------------------
interface brm_req_if;
  logic              valid;
  logic              ready;
  brm_pkg::brm_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/brm_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brm_rsp_if
// result channel with valid / ready handshake
// ---------------------------------------------------------------------------
interface brm_rsp_if;
  logic              valid;
  logic              ready;
  brm_pkg::brm_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/bytecode_register_machine_execute_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bytecode_register_machine_execute_core
// execute stage of a register bytecode machine: register file in a
// synchronous memory, instruction index, halt and syscall reporting
// ---------------------------------------------------------------------------
//
//  channel    | direction | handshake        | payload
//  -----------+-----------+------------------+-----------------------------
//  req        | in        | valid / ready    | one decoded instruction or a
//             |           |                  | write return value (cmd 1)
//  rsp        | out       | valid / ready    | next index, exit and status
//  cfg        | in        | cfg_we           | entry index (16 bits)
//
//  one request per cycle sustained while rsp is not stalled; a request goes
//  through the register-file read and execute, and its result is held in the
//  output register
//  the memory read and execute stage overlap, the last write is forwarded
//  reset clears valid bits of the register file at once, no clearing pass
//  a stalled result holds the execute stage, and req.ready follows it
//
// ---------------------------------------------------------------------------
module bytecode_register_machine_execute_core #(
  parameter int unsigned     REG_COUNT     = brm_pkg::REG_COUNT_DEF,
  parameter longint unsigned PROGRAM_DEPTH = brm_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  brm_req_if.sink     req,
  brm_rsp_if.source   rsp
);

  // register file address width
  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [8:0]  REG_LIMIT = 9'(REG_COUNT);

  // index wrap: depths of 2^16 and above reduce to a plain 16-bit wrap,
  // smaller depths use a reciprocal multiply and a back-multiply
  localparam bit              DEEP      = (PROGRAM_DEPTH >= 64'd65536);
  localparam int unsigned     DEPTH_LOG = DEEP ? 16 : $clog2(PROGRAM_DEPTH);
  localparam int unsigned     SHIFT     = 16 + DEPTH_LOG;
  localparam longint unsigned RECIP_L   =
    DEEP ? 64'd0 : ((64'd1 << SHIFT) + PROGRAM_DEPTH - 64'd1) / PROGRAM_DEPTH;
  localparam logic [17:0]     RECIP     = 18'(RECIP_L);
  localparam logic [15:0]     DEPTH_W   = DEEP ? 16'd0 : 16'(PROGRAM_DEPTH);

  // fixed registers read by the write syscall
  localparam logic [AW-1:0] R1_ADDR = AW'(1);
  localparam logic [AW-1:0] R2_ADDR = AW'(2);
  localparam bit            HAS_R2  = (REG_COUNT > 2);

  // configuration
  logic [15:0] entry_index;

  // architectural control state
  logic [15:0]        instr_index;
  logic               started;
  logic               halted;
  logic signed [63:0] r0_q;        // copy of r0 for exit and write syscalls

  // register file memory and its valid bits
  logic [63:0]          rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld;

  // execute stage
  logic              s1_valid;
  brm_pkg::brm_req_t s1;
  logic [AW-1:0]     s1_a_addr;
  logic [AW-1:0]     s1_b_addr;
  logic [15:0]       s1_q_tgt;
  logic [15:0]       s1_q_ent;
  logic [63:0]       rd_a;
  logic [63:0]       rd_b;
  logic              rd_a_vld;
  logic              rd_b_vld;

  // last register-file write, for the read that overlapped it
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [63:0]   fwd_data;

  // output register
  logic              out_valid;
  brm_pkg::brm_rsp_t out_q;

  // handshakes
  logic req_fire;
  logic s1_fire;

  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;
  assign req_fire  = req.valid && req.ready;

  // ---------------------------------------------------------------------
  // read stage: port addresses and reciprocal quotients
  // ---------------------------------------------------------------------
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;
  logic [33:0]   prod_tgt;
  logic [33:0]   prod_ent;

  always_comb begin
    if (req.data.cmd == brm_pkg::CMD_EXEC && req.data.opcode == brm_pkg::OP_SYSCALL) begin
      a_addr = R1_ADDR;
      b_addr = R2_ADDR;
    end else begin
      a_addr = req.data.src_index[AW-1:0];
      b_addr = req.data.src2_index[AW-1:0];
    end
  end

  assign prod_tgt = 34'(req.data.target_index) * 34'(RECIP);
  assign prod_ent = 34'(entry_index) * 34'(RECIP);

  // ---------------------------------------------------------------------
  // execute stage
  // ---------------------------------------------------------------------
  logic signed [63:0] op_a;
  logic signed [63:0] op_b;
  logic signed [63:0] cmp_b;
  logic               cmp_eq;
  logic               cmp_lt;
  logic               cmp_res;
  logic [15:0]        tgt_wrap;
  logic [15:0]        ent_wrap;
  logic [15:0]        cur;
  logic [15:0]        inc_wrap;
  logic               use_d;
  logic               use_s;
  logic               use_s2;
  logic               bad_reg;

  logic [15:0]        nxt;
  logic [1:0]         kind;
  logic signed [63:0] xval;
  logic [1:0]         status;
  logic               wreq;
  logic signed [63:0] wfd;
  logic signed [63:0] wad;
  logic signed [63:0] wlen;
  logic               halt_set;
  logic               exec_wr;
  logic [AW-1:0]      wr_addr;
  logic [63:0]        wr_data;
  logic               wr_en;

  // operands with forwarding of the write that overlapped the read
  assign op_a = (fwd_valid && fwd_addr == s1_a_addr) ? fwd_data :
                (rd_a_vld ? rd_a : 64'd0);
  assign op_b = (fwd_valid && fwd_addr == s1_b_addr) ? fwd_data :
                (rd_b_vld ? rd_b : 64'd0);

  // odd compare opcodes take the immediate
  assign cmp_b  = s1.opcode[0] ? s1.immediate : op_b;
  assign cmp_eq = (op_a == cmp_b);
  assign cmp_lt = (op_a < cmp_b);

  always_comb begin
    case (s1.opcode)
      brm_pkg::OP_EQ,  brm_pkg::OP_EQR:  cmp_res = cmp_eq;
      brm_pkg::OP_NEQ, brm_pkg::OP_NEQR: cmp_res = !cmp_eq;
      brm_pkg::OP_LT,  brm_pkg::OP_LTR:  cmp_res = cmp_lt;
      brm_pkg::OP_GT,  brm_pkg::OP_GTR:  cmp_res = !cmp_lt && !cmp_eq;
      brm_pkg::OP_LE,  brm_pkg::OP_LER:  cmp_res = cmp_lt || cmp_eq;
      default:                           cmp_res = !cmp_lt;
    endcase
  end

  // remainder from the registered quotient
  assign tgt_wrap = s1.target_index - 16'(32'(s1_q_tgt) * 32'(DEPTH_W));
  assign ent_wrap = s1.target_index == s1.target_index ?
                    entry_index - 16'(32'(s1_q_ent) * 32'(DEPTH_W)) : 16'd0;
  assign cur      = started ? instr_index : ent_wrap;
  // current index is always below the depth, so one compare wraps it
  assign inc_wrap = (!DEEP && cur == DEPTH_W - 16'd1) ? 16'd0 : cur + 16'd1;

  // which register numbers an opcode uses
  assign use_d  = s1.opcode inside {brm_pkg::OP_SET, brm_pkg::OP_SETR, brm_pkg::OP_SETD,
                                    brm_pkg::OP_SETC, brm_pkg::OP_SETM, brm_pkg::OP_ADD,
                                    brm_pkg::OP_ADDR, brm_pkg::OP_SUB, brm_pkg::OP_SUBR,
                                    [brm_pkg::OP_EQ:brm_pkg::OP_GER]};
  assign use_s  = s1.opcode inside {brm_pkg::OP_SETR, brm_pkg::OP_ADD, brm_pkg::OP_ADDR,
                                    brm_pkg::OP_SUB, brm_pkg::OP_SUBR, brm_pkg::OP_CGOTO,
                                    [brm_pkg::OP_EQ:brm_pkg::OP_GER]};
  assign use_s2 = s1.opcode inside {brm_pkg::OP_ADDR, brm_pkg::OP_SUBR, brm_pkg::OP_EQR,
                                    brm_pkg::OP_NEQR, brm_pkg::OP_LTR, brm_pkg::OP_GTR,
                                    brm_pkg::OP_LER, brm_pkg::OP_GER};
  assign bad_reg = (use_d  && {1'b0, s1.dst_index}  >= REG_LIMIT) ||
                   (use_s  && {1'b0, s1.src_index}  >= REG_LIMIT) ||
                   (use_s2 && {1'b0, s1.src2_index} >= REG_LIMIT);

  always_comb begin
    nxt      = cur;
    kind     = brm_pkg::EXIT_RUN;
    xval     = '0;
    status   = brm_pkg::ST_OK;
    wreq     = 1'b0;
    wfd      = '0;
    wad      = '0;
    wlen     = '0;
    halt_set = 1'b0;
    exec_wr  = 1'b0;
    wr_addr  = s1.dst_index[AW-1:0];
    wr_data  = '0;
    if (halted) begin
      status = brm_pkg::ST_HALTED;
    end else if (s1.cmd == brm_pkg::CMD_RET) begin
      // write syscall return value lands in r0
      exec_wr = 1'b1;
      wr_addr = '0;
      wr_data = s1.return_value;
    end else if (s1.opcode > brm_pkg::OP_GER) begin
      status = brm_pkg::ST_BAD_OP;
    end else if (bad_reg) begin
      status = brm_pkg::ST_BAD_REG;
    end else begin
      nxt = inc_wrap;
      case (s1.opcode)
        brm_pkg::OP_END: begin
          halt_set = 1'b1;
          kind     = brm_pkg::EXIT_END;
          nxt      = cur;
        end
        brm_pkg::OP_SET: begin
          exec_wr = 1'b1;
          wr_data = s1.immediate;
        end
        brm_pkg::OP_SETR: begin
          exec_wr = 1'b1;
          wr_data = op_a;
        end
        brm_pkg::OP_SETD, brm_pkg::OP_SETC, brm_pkg::OP_SETM: begin
          exec_wr = 1'b1;
          wr_data = s1.table_value;
        end
        brm_pkg::OP_ADD: begin
          exec_wr = 1'b1;
          wr_data = op_a + s1.immediate;
        end
        brm_pkg::OP_ADDR: begin
          exec_wr = 1'b1;
          wr_data = op_a + op_b;
        end
        brm_pkg::OP_SUB: begin
          exec_wr = 1'b1;
          wr_data = op_a - s1.immediate;
        end
        brm_pkg::OP_SUBR: begin
          exec_wr = 1'b1;
          wr_data = op_a - op_b;
        end
        brm_pkg::OP_SYSCALL: begin
          if (s1.syscall_number == brm_pkg::SYS_EXIT) begin
            halt_set = 1'b1;
            kind     = brm_pkg::EXIT_SYS;
            xval     = r0_q;
          end else if (s1.syscall_number == brm_pkg::SYS_WRITE) begin
            wreq = 1'b1;
            wfd  = r0_q;
            wad  = op_a;
            wlen = HAS_R2 ? op_b : 64'sd0;
          end else begin
            halt_set = 1'b1;
            kind     = brm_pkg::EXIT_UNKNOWN;
          end
        end
        brm_pkg::OP_GOTO: begin
          nxt = tgt_wrap;
        end
        brm_pkg::OP_CGOTO: begin
          if (op_a != 64'sd0) begin
            nxt = tgt_wrap;
          end
        end
        brm_pkg::OP_EQ,  brm_pkg::OP_EQR,  brm_pkg::OP_NEQ, brm_pkg::OP_NEQR,
        brm_pkg::OP_LT,  brm_pkg::OP_LTR,  brm_pkg::OP_GT,  brm_pkg::OP_GTR,
        brm_pkg::OP_LE,  brm_pkg::OP_LER,  brm_pkg::OP_GE,  brm_pkg::OP_GER: begin
          exec_wr = 1'b1;
          wr_data = {63'd0, cmp_res};
        end
        default: begin
          // nop and mark only advance
        end
      endcase
    end
  end

  assign wr_en = s1_fire && exec_wr;

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------

  // register file memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
    if (req_fire) begin
      rd_a <= rf_mem[a_addr];
      rd_b <= rf_mem[b_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_index <= '0;
      instr_index <= '0;
      started     <= 1'b0;
      halted      <= 1'b0;
      r0_q        <= '0;
      rf_vld      <= '0;
      rd_a_vld    <= 1'b0;
      rd_b_vld    <= 1'b0;
      s1_valid    <= 1'b0;
      fwd_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_index <= cfg_wdata;
      end
      if (req_fire) begin
        rd_a_vld <= rf_vld[a_addr];
        rd_b_vld <= rf_vld[b_addr];
      end
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        instr_index <= nxt;
        started     <= 1'b1;
        fwd_valid   <= exec_wr;
        if (halt_set) begin
          halted <= 1'b1;
        end
        if (exec_wr) begin
          rf_vld[wr_addr] <= 1'b1;
          if (wr_addr == '0) begin
            r0_q <= wr_data;
          end
        end
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1        <= req.data;
      s1_a_addr <= a_addr;
      s1_b_addr <= b_addr;
      s1_q_tgt  <= 16'(prod_tgt >> SHIFT);
      s1_q_ent  <= 16'(prod_ent >> SHIFT);
    end
    if (s1_fire) begin
      fwd_addr            <= wr_addr;
      fwd_data            <= wr_data;
      out_q.next_index    <= nxt;
      out_q.exit_kind     <= kind;
      out_q.exit_value    <= xval;
      out_q.status        <= status;
      out_q.write_request <= wreq;
      out_q.write_fd      <= wfd;
      out_q.write_addr    <= wad;
      out_q.write_len     <= wlen;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // a halted machine never touches the register file
  a_no_write_halted : assert property (@(posedge clk) disable iff (rst)
    halted |-> !wr_en)
    else $error("register file written after halt");

  // the r0 copy tracks every write into entry zero
  a_r0_copy : assert property (@(posedge clk) disable iff (rst)
    (wr_en && wr_addr == '0) |=> (r0_q == $past(wr_data)))
    else $error("r0 copy out of step with register file");

  // a write request only comes from a running, successful syscall
  a_wreq_clean : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.write_request) |->
      (rsp.data.exit_kind == brm_pkg::EXIT_RUN && rsp.data.status == brm_pkg::ST_OK))
    else $error("write request with exit or error status");

  // once the entry index is taken it is never taken again
  a_started_sticks : assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped without reset");

endmodule
